FILE: src/srdp_pkg.sv
// Shared constants, codes and types of the sparse row dot product unit.
`timescale 1ns / 1ps
package srdp_pkg;

  // Field and storage widths.
  localparam int unsigned ColumnW    = 12;
  localparam int unsigned VecDepth   = 1 << ColumnW;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned RowNumW    = 16;
  localparam int unsigned RowCountW  = 17;
  localparam int unsigned AccW       = 48;
  localparam int unsigned ProdW      = 2 * ValueW;
  localparam int unsigned FracW      = 16;

  // Configuration port geometry.
  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;
  localparam int unsigned RegIdxW    = PaddrW - 2;

  localparam logic [RowCountW-1:0] RowCountReset = RowCountW'(1);
  localparam logic [RowCountW-1:0] RowCountMax   = RowCountW'(65536);

  // Item operation codes.
  typedef enum logic {
    OpLoad   = 1'b0,
    OpMatrix = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [RegIdxW-1:0] {
    RegRowCount = 1'b0
  } reg_idx_e;

  // Item handed from the multiply stage to the accumulate stage.
  typedef struct packed {
    logic                   valid;
    logic                   is_matrix;
    logic                   row_end;
    logic signed [AccW-1:0] product;
  } prod_item_t;

endpackage

FILE: src/srdp_if.sv
// Handshake channel interfaces for input items and row results.
`timescale 1ns / 1ps
interface srdp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [srdp_pkg::ColumnW-1:0]          column;
  logic signed [srdp_pkg::ValueW-1:0]    value;
  logic                                  row_end;

  modport source (output valid, operation, column, value, row_end, input ready);
  modport sink   (input valid, operation, column, value, row_end, output ready);
endinterface

interface srdp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [srdp_pkg::RowNumW-1:0]          row_number;
  logic signed [srdp_pkg::ValueW-1:0]    row_sum;
  logic                                  last_row;

  modport source (output valid, row_number, row_sum, last_row, input ready);
  modport sink   (input valid, row_number, row_sum, last_row, output ready);
endinterface

FILE: src/sparse_row_dot_product_unit.sv
// Top level of the sparse row dot product unit.
//
// Streams a sparse matrix in row order against a dense Q16.16 vector.
// The input channel carries load transactions (operation 0), which write
// one vector element at the given column and restart the row number, and
// matrix transactions (operation 1), which multiply a nonzero by the
// stored element of its column and add the product into the row sum.
// A matrix transaction with row_end set emits one transaction on the
// output channel: the row number, the saturated row sum and a flag for
// the final row. The row count register sits on the APB-style port.
// Throughput is one input transaction per cycle while the output is not
// stalled, set by the single vector read and single multiply-accumulate per
// item. The result is registered in turn: the vector read happens at the
// accepting clock edge, then come the multiply register and the accumulate
// into the output register.
// When the receiver stalls, the multiply and read stages keep taking
// transactions until they are full; items without results still drain.
// Reset clears the accumulator, the row number and the row count (to 1);
// the vector memory is not cleared and must be loaded before use.
`timescale 1ns / 1ps
module sparse_row_dot_product_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srdp_in_if.sink                      in_i,
  srdp_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srdp_pkg::PaddrW-1:0]  paddr,
  input  logic [srdp_pkg::PdataW-1:0]  pwdata,
  output logic [srdp_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import srdp_pkg::*;

  logic                     s1_valid_q;
  logic                     s1_is_matrix_q;
  logic                     s1_row_end_q;
  logic signed [ValueW-1:0] s1_value_q;
  logic                     s1_ready;
  logic                     in_accept;
  logic                     in_is_matrix;
  logic signed [ValueW-1:0] vec_data;
  prod_item_t               s2_item;
  logic                     s2_ready;
  logic [RowCountW-1:0]     row_count;

  assign in_is_matrix = (in_i.operation == OpMatrix);
  assign in_i.ready   = !s1_valid_q || s1_ready;
  assign in_accept    = in_i.valid && in_i.ready;

  // Configuration registers.
  srdp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .row_count_o (row_count)
  );

  // Vector memory: loads write, matrix items read at acceptance.
  srdp_vec_store u_vec_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && !in_is_matrix),
    .wr_addr_i (in_i.column),
    .wr_data_i (in_i.value),
    .rd_en_i   (in_accept && in_is_matrix),
    .rd_addr_i (in_i.column),
    .rd_data_o (vec_data)
  );

  // Input register stage, aligned with the memory read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_is_matrix_q <= in_is_matrix;
      s1_row_end_q   <= in_i.row_end;
      s1_value_q     <= in_i.value;
    end
  end

  // Multiply stage.
  srdp_mul u_mul (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid_q),
    .s1_is_matrix_i (s1_is_matrix_q),
    .s1_row_end_i   (s1_row_end_q),
    .s1_value_i     (s1_value_q),
    .vec_data_i     (vec_data),
    .s1_ready_o     (s1_ready),
    .s2_ready_i     (s2_ready),
    .s2_item_o      (s2_item)
  );

  // Accumulate stage and result register.
  srdp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_item_i   (s2_item),
    .s2_ready_o  (s2_ready),
    .row_count_i (row_count),
    .out_o       (out_o)
  );

endmodule

FILE: src/srdp_vec_store.sv
// Dense vector memory: one write port and one registered read port.
`timescale 1ns / 1ps
module srdp_vec_store (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [srdp_pkg::ColumnW-1:0]        wr_addr_i,
  input  logic [srdp_pkg::ValueW-1:0]         wr_data_i,
  input  logic                                rd_en_i,
  input  logic [srdp_pkg::ColumnW-1:0]        rd_addr_i,
  output logic signed [srdp_pkg::ValueW-1:0]  rd_data_o
);
  import srdp_pkg::*;

  logic [ValueW-1:0] mem_q [VecDepth];
  logic [ValueW-1:0] rd_data_q;

  // Entries hold garbage until loaded; no clearing is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = $signed(rd_data_q);

endmodule

FILE: src/srdp_regs.sv
// APB-style configuration register block holding the row count.
`timescale 1ns / 1ps
module srdp_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srdp_pkg::PaddrW-1:0]    paddr,
  input  logic [srdp_pkg::PdataW-1:0]    pwdata,
  output logic [srdp_pkg::PdataW-1:0]    prdata,
  output logic                           pready,
  output logic [srdp_pkg::RowCountW-1:0] row_count_o
);
  import srdp_pkg::*;

  logic [RowCountW-1:0] row_count_q;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 wr_row_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_row_count = psel && penable && pwrite && pready && (reg_idx == RegRowCount);

  // Register write on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RowCountReset;
    end else if (wr_row_count) begin
      row_count_q <= pwdata[RowCountW-1:0];
    end
  end

  // Read data; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (psel && (reg_idx == RegRowCount)) begin
      prdata = PdataW'(row_count_q);
    end
  end

  assign row_count_o = row_count_q;

endmodule

FILE: src/srdp_mul.sv
// Multiply stage: nonzero times vector entry, scaled back to Q32.16.
`timescale 1ns / 1ps
module srdp_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s1_valid_i,
  input  logic                               s1_is_matrix_i,
  input  logic                               s1_row_end_i,
  input  logic signed [srdp_pkg::ValueW-1:0] s1_value_i,
  input  logic signed [srdp_pkg::ValueW-1:0] vec_data_i,
  output logic                               s1_ready_o,
  input  logic                               s2_ready_i,
  output srdp_pkg::prod_item_t               s2_item_o
);
  import srdp_pkg::*;

  logic                    valid_q;
  logic                    is_matrix_q;
  logic                    row_end_q;
  logic signed [AccW-1:0]  product_q;
  logic signed [ProdW-1:0] full_product;

  // Stage moves when empty or when its item leaves this cycle.
  assign s1_ready_o = !valid_q || s2_ready_i;

  // Full Q32.32 product; dropping the low bits floors toward minus infinity.
  assign full_product = s1_value_i * vec_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && s1_valid_i) begin
      is_matrix_q <= s1_is_matrix_i;
      row_end_q   <= s1_row_end_i;
      product_q   <= full_product[FracW +: AccW];
    end
  end

  assign s2_item_o.valid     = valid_q;
  assign s2_item_o.is_matrix = is_matrix_q;
  assign s2_item_o.row_end   = row_end_q;
  assign s2_item_o.product   = product_q;

endmodule

FILE: src/srdp_accum.sv
// Accumulate stage: saturating row sum, row counter and result register.
`timescale 1ns / 1ps
module srdp_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srdp_pkg::prod_item_t           s2_item_i,
  output logic                           s2_ready_o,
  input  logic [srdp_pkg::RowCountW-1:0] row_count_i,
  srdp_out_if.source                     out_o
);
  import srdp_pkg::*;

  logic signed [AccW-1:0]   acc_q;
  logic [RowNumW-1:0]       cnt_q;
  logic                     out_valid_q;
  logic [RowNumW-1:0]       out_row_q;
  logic signed [ValueW-1:0] out_sum_q;
  logic                     out_last_q;

  logic                     produces;
  logic                     out_free;
  logic                     advance;
  logic signed [AccW:0]     sum_wide;
  logic signed [AccW-1:0]   sum_sat;
  logic signed [ValueW-1:0] sum_out;
  logic [RowCountW-1:0]     eff_rows;
  logic [RowCountW-1:0]     cnt_inc;
  logic                     is_last;

  // Only a matrix item closing its row needs the result register.
  assign produces   = s2_item_i.is_matrix && s2_item_i.row_end;
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = s2_item_i.valid && (!produces || out_free);
  assign s2_ready_o = !s2_item_i.valid || !produces || out_free;

  // Accumulator add, saturated to the signed 48-bit range.
  assign sum_wide = {acc_q[AccW-1], acc_q} + {s2_item_i.product[AccW-1], s2_item_i.product};
  always_comb begin
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      sum_sat = sum_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[AccW-1:0];
    end
  end

  // Row sum narrowed to Q16.16 with saturation.
  always_comb begin
    if (sum_sat[AccW-1:ValueW-1] == '0 || sum_sat[AccW-1:ValueW-1] == '1) begin
      sum_out = sum_sat[ValueW-1:0];
    end else if (sum_sat[AccW-1]) begin
      sum_out = {1'b1, {(ValueW-1){1'b0}}};
    end else begin
      sum_out = {1'b0, {(ValueW-1){1'b1}}};
    end
  end

  // Final-row test against the clamped row count.
  always_comb begin
    if (row_count_i == '0) begin
      eff_rows = RowCountW'(1);
    end else if (row_count_i > RowCountMax) begin
      eff_rows = RowCountMax;
    end else begin
      eff_rows = row_count_i;
    end
  end
  assign cnt_inc = {1'b0, cnt_q} + RowCountW'(1);
  assign is_last = (cnt_inc >= eff_rows);

  // Accumulator and row counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (advance) begin
      if (!s2_item_i.is_matrix) begin
        cnt_q <= '0;
      end else if (s2_item_i.row_end) begin
        acc_q <= '0;
        cnt_q <= is_last ? '0 : cnt_inc[RowNumW-1:0];
      end else begin
        acc_q <= sum_sat;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produces) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_row_q  <= cnt_q;
      out_sum_q  <= sum_out;
      out_last_q <= is_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_number = out_row_q;
  assign out_o.row_sum    = out_sum_q;
  assign out_o.last_row   = out_last_q;

endmodule

FILE: bench/sparse_row_dot_product_unit_test.sv
// Self-checking testbench of the sparse row dot product unit.
`timescale 1ns / 1ps
module sparse_row_dot_product_unit_test;
  import srdp_pkg::*;

  localparam int unsigned ClkPeriod    = 12;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned PhaseItems   = 130;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned NumSettings  = 9;

  // Register index past the end of the map; writes to it must be ignored.
  localparam logic [RegIdxW-1:0] RegSpare = 1'b1;

  localparam logic signed [ValueW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValueW-1:0] QMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] QOne = 32'sh0001_0000;

  typedef struct packed {
    op_e                      operation;
    logic [ColumnW-1:0]       column;
    logic signed [ValueW-1:0] value;
    logic                     row_end;
  } stream_item_t;

  typedef struct packed {
    logic [RowNumW-1:0]       row_number;
    logic signed [ValueW-1:0] row_sum;
    logic                     last_row;
  } row_result_t;

  typedef struct packed {
    stream_item_t item;
    logic         typed;
    row_result_t  want;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  srdp_in_if  in_ch ();
  srdp_out_if out_ch ();

  sparse_row_dot_product_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the vector store, accumulator, row counter and row count.
  logic [ValueW-1:0]      vec_image [VecDepth];
  bit                     col_loaded [VecDepth];
  int unsigned            loaded_cols [$];
  logic signed [AccW-1:0] acc_image = '0;
  logic [RowNumW-1:0]     row_image = '0;
  logic [RowCountW-1:0]   rows_setting = RowCountReset;

  row_result_t   pending_rows [$];
  directed_row_t directed_rows [$];
  int unsigned   fail_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   items_sent = 0;
  bit            src_burst = 1'b0;
  bit            sink_burst = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Advance the shadow state by one accepted transaction and work out its row result.
  task automatic advance_dot_product(input stream_item_t it, output bit emits,
                                     output row_result_t row);
    logic signed [ValueW-1:0] elem;
    logic signed [ProdW-1:0]  product;
    logic signed [AccW-1:0]   scaled;
    logic [AccW:0]            total;
    int                       eff_rows;
    emits = 1'b0;
    row = '0;
    if (it.operation == OpLoad) begin
      vec_image[it.column] = it.value;
      if (!col_loaded[it.column]) begin
        col_loaded[it.column] = 1'b1;
        loaded_cols.push_back(it.column);
      end
      row_image = '0;
      return;
    end
    // Q16.16 times Q16.16, low 16 bits dropped (floor), then a saturating 48-bit add.
    elem = vec_image[it.column];
    product = ProdW'($signed(it.value)) * ProdW'(elem);
    scaled = AccW'(product >>> FracW);
    total = {acc_image[AccW-1], acc_image} + {scaled[AccW-1], scaled};
    if (total[AccW] != total[AccW-1]) begin
      acc_image = total[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_image = total[AccW-1:0];
    end
    if (!it.row_end) return;
    // Finished row: clamp the sum to 32 bits and step the row counter.
    emits = 1'b1;
    row.row_number = row_image;
    if (&acc_image[AccW-1:ValueW-1] || ~|acc_image[AccW-1:ValueW-1]) begin
      row.row_sum = acc_image[ValueW-1:0];
    end else begin
      row.row_sum = acc_image[AccW-1] ? QMin : QMax;
    end
    if (rows_setting == '0) begin
      eff_rows = 1;
    end else if (rows_setting > RowCountMax) begin
      eff_rows = int'(RowCountMax);
    end else begin
      eff_rows = int'(rows_setting);
    end
    row.last_row = (int'(row_image) + 1 >= eff_rows);
    acc_image = '0;
    row_image = row.last_row ? '0 : row_image + 1'b1;
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < ReportLimit) $display("%s", msg);
    fail_count++;
  endtask

  // Offer one input transaction after a random gap and record what it should produce.
  task automatic send_item(input stream_item_t it, input bit typed,
                           input row_result_t typed_row);
    int unsigned gap;
    bit          emits;
    row_result_t row;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.column    <= it.column;
    in_ch.value     <= it.value;
    in_ch.row_end   <= it.row_end;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    advance_dot_product(it, emits, row);
    if (emits) pending_rows.push_back(typed ? typed_row : row);
  endtask

  task automatic send_fields(input op_e op, input int unsigned col,
                             input logic [ValueW-1:0] val, input logic end_bit);
    stream_item_t it;
    it.operation = op;
    it.column = ColumnW'(col);
    it.value = val;
    it.row_end = end_bit;
    send_item(it, 1'b0, '0);
  endtask

  // Mix of zeros, extremes, full-range words and small Q16.16 numbers.
  function automatic logic [ValueW-1:0] draw_q16();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return QMax;
      2: return QMin;
      3, 4: return $urandom();
      default: return ValueW'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic int unsigned pick_column();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  // One well-formed row: nonzeros from loaded columns, the last one closing the row.
  task automatic send_row(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_fields(OpMatrix, pick_column(), draw_q16(), k == len - 1);
    end
  endtask

  // Drop valid, let every expected row arrive and the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [RegIdxW-1:0] idx,
                                input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegRowCount) rows_setting = data[RowCountW-1:0];
  endtask

  task automatic push_directed(input op_e op, input int unsigned col,
                               input logic [ValueW-1:0] val, input logic end_bit,
                               input logic typed, input logic [ValueW-1:0] sum);
    directed_row_t d;
    d.item.operation = op;
    d.item.column = ColumnW'(col);
    d.item.value = val;
    d.item.row_end = end_bit;
    d.typed = typed;
    // The row count is one here, so every typed row is row zero and the final one.
    d.want.row_number = '0;
    d.want.row_sum = sum;
    d.want.last_row = 1'b1;
    directed_rows.push_back(d);
  endtask

  task automatic check_row();
    row_result_t want;
    if (pending_rows.size() == 0) begin
      note_failure($sformatf("unexpected row result: row %0d sum %h last %0b",
                             out_ch.row_number, out_ch.row_sum, out_ch.last_row));
      return;
    end
    want = pending_rows.pop_front();
    if (out_ch.row_number !== want.row_number) begin
      note_failure($sformatf("row_number mismatch: expected %0d, got %0d",
                             want.row_number, out_ch.row_number));
    end
    if (out_ch.row_sum !== want.row_sum) begin
      note_failure($sformatf("row_sum mismatch on row %0d: expected %h, got %h",
                             want.row_number, want.row_sum, out_ch.row_sum));
    end
    if (out_ch.last_row !== want.last_row) begin
      note_failure($sformatf("last_row mismatch on row %0d: expected %0b, got %0b",
                             want.row_number, want.last_row, out_ch.last_row));
    end
  endtask

  // Result receiver with a random stall before each transaction.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      check_row();
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed table, then random phases under several row counts.
  initial begin
    logic [PdataW-1:0] row_settings [NumSettings];
    int unsigned       phase_start;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OpLoad;
    in_ch.column    <= '0;
    in_ch.value     <= '0;
    in_ch.row_end   <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Vector elements at the extremes; row_end on a load has no effect.
    push_directed(OpLoad, 0, QOne, 1'b0, 1'b0, '0);
    push_directed(OpLoad, VecDepth - 1, QMax, 1'b0, 1'b0, '0);
    push_directed(OpLoad, 1, QMin, 1'b1, 1'b0, '0);
    push_directed(OpLoad, 2, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    push_directed(OpLoad, 3, '0, 1'b0, 1'b0, '0);
    // Single-nonzero rows: plain product, zero element, zero-padded entry,
    // both clamps of the row sum and truncation toward minus infinity.
    push_directed(OpMatrix, 0, 32'h0002_0000, 1'b1, 1'b1, 32'h0002_0000);
    push_directed(OpMatrix, 3, 32'h1234_5678, 1'b1, 1'b1, '0);
    push_directed(OpMatrix, 0, '0, 1'b1, 1'b1, '0);
    push_directed(OpMatrix, VecDepth - 1, QMax, 1'b1, 1'b1, QMax);
    push_directed(OpMatrix, 1, QMax, 1'b1, 1'b1, QMin);
    push_directed(OpMatrix, 1, QMin, 1'b1, 1'b1, QMax);
    push_directed(OpMatrix, 2, 32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // Accumulator pinned at its positive limit, then pulled back down.
    repeat (3) push_directed(OpMatrix, 1, QMin, 1'b0, 1'b0, '0);
    push_directed(OpMatrix, 1, QMax, 1'b0, 1'b0, '0);
    push_directed(OpMatrix, 1, QMax, 1'b1, 1'b1, 32'h0000_FFFF);
    // Accumulator pinned at its negative limit, then pulled back up.
    repeat (3) push_directed(OpMatrix, 1, QMax, 1'b0, 1'b0, '0);
    push_directed(OpMatrix, 1, QMin, 1'b0, 1'b0, '0);
    push_directed(OpMatrix, 1, QMin, 1'b1, 1'b1, '0);
    // A load in the middle of a row keeps the partial sum.
    push_directed(OpMatrix, 0, QOne, 1'b0, 1'b0, '0);
    push_directed(OpLoad, 5, 32'h0003_0000, 1'b1, 1'b0, '0);
    push_directed(OpMatrix, 5, QOne, 1'b1, 1'b1, 32'h0004_0000);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // Row counts: largest, zero, above range, ten, then two lowered under the
    // running counter, stray upper bits, one, seven and a random small one.
    row_settings = '{32'd65536, 32'd0, 32'd131071, 32'd10, 32'd2, 32'hFFFE_0003,
                     32'd1, 32'd7, 32'd0};
    row_settings[NumSettings - 1] = $urandom_range(1, 16);

    foreach (row_settings[p]) begin
      settle();
      write_register(RegRowCount, row_settings[p]);
      if (p == 3) write_register(RegSpare, 32'd1);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(0, 15) == 0) src_burst = !src_burst;
        if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 4)) begin
              send_fields(OpLoad, $urandom_range(0, VecDepth - 1), draw_q16(),
                          1'($urandom_range(0, 1)));
            end
          end
          1: begin
            // Broken row: a few nonzeros cut short by a load.
            repeat ($urandom_range(1, 3)) send_fields(OpMatrix, pick_column(), draw_q16(), 1'b0);
            send_fields(OpLoad, $urandom_range(0, VecDepth - 1), draw_q16(),
                        1'($urandom_range(0, 1)));
          end
          default: send_row($urandom_range(1, 6));
        endcase
      end
      // Restart the row number, then leave it mid-count for the next setting.
      send_fields(OpLoad, $urandom_range(0, VecDepth - 1), draw_q16(), 1'b0);
      repeat (6) send_row($urandom_range(1, 4));
    end

    settle();
    if (fail_count == 0 && pending_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
